// ===== rtl/core/ujse_pkg.sv =====
// ----------------------------------------------------------------------------
// ujse_pkg
// Shared types, codes and helpers for the UTF-8 to escaped-text converter.
// ----------------------------------------------------------------------------
package ujse_pkg;

  // Kind of character run that one input byte produces
  typedef enum logic [2:0] {
    RK_NONE,  // no output (gathering, or discarding)
    RK_CHAR,  // byte copied as is
    RK_ESC,   // backslash + letter
    RK_UNI,   // \uXXXX
    RK_PAIR,  // \uXXXX\uXXXX surrogate pair
    RK_WIDE,  // \UXXXXXXXX
    RK_ERR    // single error result
  } run_kind_t;

  // Run lengths, in characters
  localparam logic [3:0] LEN_CHAR = 4'd1;
  localparam logic [3:0] LEN_ESC  = 4'd2;
  localparam logic [3:0] LEN_UNI  = 4'd6;
  localparam logic [3:0] LEN_PAIR = 4'd12;
  localparam logic [3:0] LEN_WIDE = 4'd10;
  localparam logic [3:0] LEN_ERR  = 4'd1;

  // Character positions inside \u and \U escapes
  localparam logic [3:0] POS_BS_0  = 4'd0;
  localparam logic [3:0] POS_TAG_0 = 4'd1;
  localparam logic [3:0] POS_BS_1  = 4'd6;
  localparam logic [3:0] POS_TAG_1 = 4'd7;

  localparam logic [20:0] PLANE1_BASE = 21'h010000;
  localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // One decoded run handed from decoder to emitter
  typedef struct packed {
    run_kind_t   kind;
    logic [7:0]  ch;     // literal or escape letter
    logic [31:0] hexv;   // hex digits, most significant nibble first
    logic [3:0]  len;    // characters in the run
    logic        eos;    // run belongs to the string's last byte
  } run_t;

  // Lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h57 + {4'd0, n};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ujse_decode.sv =====
// ----------------------------------------------------------------------------
// ujse_decode
// UTF-8 sequence tracker; turns one byte into a run descriptor.
// ----------------------------------------------------------------------------
module ujse_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_in,
  input  logic          eos,
  input  logic          surrogate_mode,
  input  logic          step,
  output ujse_pkg::run_t run
);
  import ujse_pkg::*;

  logic [20:0] acc, acc_next;
  logic [1:0]  remaining, remaining_next;
  logic        discard, discard_next;

  logic [20:0] acc_sh;
  logic [1:0]  rem_dec;
  logic [20:0] off;
  logic [15:0] hi_w, lo_w;
  logic [7:0]  esc;

  assign acc_sh  = {acc[14:0], byte_in[5:0]};
  assign rem_dec = remaining - 2'd1;
  assign off     = acc_sh - PLANE1_BASE;
  assign hi_w    = HI_SURR | {6'd0, off[19:10]};
  assign lo_w    = LO_SURR | {6'd0, off[9:0]};

  always_comb begin
    unique case (byte_in)
      8'h22:   esc = 8'h22;
      8'h5C:   esc = 8'h5C;
      8'h08:   esc = 8'h62;
      8'h0C:   esc = 8'h66;
      8'h0A:   esc = 8'h6E;
      8'h0D:   esc = 8'h72;
      8'h09:   esc = 8'h74;
      default: esc = 8'h00;
    endcase
  end

  always_comb begin
    run.kind       = RK_NONE;
    run.ch         = byte_in;
    run.hexv       = 32'd0;
    run.len        = LEN_CHAR;
    run.eos        = eos;
    acc_next       = acc;
    remaining_next = remaining;
    discard_next   = discard;

    priority if (discard) begin
      run.kind = RK_NONE;
    end else if (remaining != 2'd0) begin
      if (byte_in[7:6] != 2'b10) begin
        run.kind = RK_ERR;
      end else begin
        acc_next       = acc_sh;
        remaining_next = rem_dec;
        if (rem_dec != 2'd0) begin
          run.kind = eos ? RK_ERR : RK_NONE;
        end else if (acc_sh > CODE_MAX) begin
          run.kind = RK_ERR;
        end else begin
          acc_next = 21'd0;
          priority if (acc_sh < PLANE1_BASE) begin
            run.kind = RK_UNI;
            run.hexv = {acc_sh[15:0], 16'd0};
            run.len  = LEN_UNI;
          end else if (surrogate_mode) begin
            run.kind = RK_PAIR;
            run.hexv = {hi_w, lo_w};
            run.len  = LEN_PAIR;
          end else begin
            run.kind = RK_WIDE;
            run.hexv = {11'd0, acc_sh};
            run.len  = LEN_WIDE;
          end
        end
      end
    end else if (byte_in[7:6] == 2'b11) begin
      if (byte_in >= 8'hF8) begin
        run.kind = RK_ERR;
      end else begin
        priority if (byte_in < 8'hE0) begin
          acc_next       = {16'd0, byte_in[4:0]};
          remaining_next = 2'd1;
        end else if (byte_in < 8'hF0) begin
          acc_next       = {17'd0, byte_in[3:0]};
          remaining_next = 2'd2;
        end else begin
          acc_next       = {18'd0, byte_in[2:0]};
          remaining_next = 2'd3;
        end
        run.kind = eos ? RK_ERR : RK_NONE;
      end
    end else if (esc != 8'h00) begin
      run.kind = RK_ESC;
      run.ch   = esc;
      run.len  = LEN_ESC;
    end else begin
      run.kind = RK_CHAR;
    end

    // error: reset sequence state, drop bytes to the end of the string
    if (run.kind == RK_ERR) begin
      run.ch         = CH_NUL;
      run.len        = LEN_ERR;
      acc_next       = 21'd0;
      remaining_next = 2'd0;
      discard_next   = 1'b1;
    end
    if (eos) begin
      acc_next       = 21'd0;
      remaining_next = 2'd0;
      discard_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 21'd0;
      remaining <= 2'd0;
      discard   <= 1'b0;
    end else if (step) begin
      acc       <= acc_next;
      remaining <= remaining_next;
      discard   <= discard_next;
    end
  end

endmodule

// ===== rtl/core/ujse_emit.sv =====
// ----------------------------------------------------------------------------
// ujse_emit
// Holds one run and sends its characters, one per cycle while the output is not stalled, into the result register.
// ----------------------------------------------------------------------------
module ujse_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  ujse_pkg::run_t run_in,
  output logic           run_free,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           run_last,
  output logic           error_flag,
  output logic           string_done
);
  import ujse_pkg::*;

  run_t       run;
  logic       run_valid;
  logic [3:0] idx;
  logic [31:0] hexv;

  logic       send, done, is_bs, is_tag, is_hex;
  logic [7:0] ch;

  assign send     = run_valid && (!out_valid || !out_stall);
  assign done     = send && (idx == run.len - 4'd1);
  assign run_free = !run_valid || done;

  always_comb begin
    is_bs  = (idx == POS_BS_0)  || (run.kind == RK_PAIR && idx == POS_BS_1);
    is_tag = (idx == POS_TAG_0) || (run.kind == RK_PAIR && idx == POS_TAG_1);
    is_hex = 1'b0;
    unique case (run.kind)
      RK_CHAR: ch = run.ch;
      RK_ESC:  ch = is_bs ? CH_BSLASH : run.ch;
      RK_UNI, RK_PAIR, RK_WIDE: begin
        priority if (is_bs) begin
          ch = CH_BSLASH;
        end else if (is_tag) begin
          ch = (run.kind == RK_WIDE) ? CH_UP_U : CH_LOW_U;
        end else begin
          ch     = hex_char(hexv[31:28]);
          is_hex = 1'b1;
        end
      end
      default: ch = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= 4'd0;
    end else if (done) begin
      run_valid <= 1'b0;
    end else if (send) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run  <= run_in;
      hexv <= run_in.hexv;
    end else if (send && is_hex) begin
      hexv <= {hexv[27:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_char    <= ch;
      run_last    <= (idx == run.len - 4'd1);
      error_flag  <= (run.kind == RK_ERR);
      string_done <= (idx == run.len - 4'd1) && run.eos;
    end
  end

endmodule

// ===== rtl/core/utf8_json_string_escaper.sv =====
// ----------------------------------------------------------------------------
// utf8_json_string_escaper
// UTF-8 byte stream in, escaped JSON-style text out, one character per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request is one byte of a UTF-8
// string, with end_of_string on its final byte.
// Output channel (out_valid / out_stall): one request is one escaped
// character; run_last marks the last character caused by an input byte,
// string_done the last one of the string, error_flag a malformed sequence
// (out_char is then zero and the rest of the string is dropped).
// Config channel (cfg_valid / cfg_ready / cfg_data): surrogate_mode; the user
// must write it only while idle (not enforced); cfg_ready is always high.
// Pipeline: input register -> decode -> run register -> result register.
// A plain byte passes the input and run registers before the result register.
// Throughput: one character per cycle out of the run emitter while out_stall
// is low. A plain byte makes one character, an escape 2, \u 6, \U 10 and a
// surrogate pair 12 characters; bytes that only gather sequence bits produce
// nothing. The next byte is decoded during the last character of the current
// run, so runs follow each other without gaps.
// When the receiver stalls the result register holds; the run register and
// then the input register fill and in_stall rises.
// Reset (rst, synchronous) empties all stages, clears sequence state and
// sets surrogate_mode to 1.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       error_flag,
  output logic       string_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import ujse_pkg::*;

  // config register
  logic surrogate_mode;

  // input register
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_eos;

  // decoder -> emitter
  run_t run;
  logic run_free;
  logic advance;
  logic load_run;
  logic accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surrogate_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      surrogate_mode <= cfg_data;
    end
  end

  // byte leaves the input register: always when it makes no output,
  // otherwise only once the emitter can take a new run
  assign advance  = ir_valid && (run.kind == RK_NONE || run_free);
  assign load_run = advance && (run.kind != RK_NONE);
  assign in_stall = ir_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (accept) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_byte <= in_byte;
      ir_eos  <= end_of_string;
    end
  end

  ujse_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .byte_in        (ir_byte),
    .eos            (ir_eos),
    .surrogate_mode (surrogate_mode),
    .step           (advance),
    .run            (run)
  );

  ujse_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load_run),
    .run_in      (run),
    .run_free    (run_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .error_flag  (error_flag),
    .string_done (string_done)
  );

  // error result is a lone zero character closing its byte's run
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> out_char == CH_NUL && run_last)
    else $error("error result malformed");

  // string end mark only on the last character of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");

  // a new run is loaded only into a free emitter
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_run |-> run_free)
    else $error("run loaded over a busy emitter");

  // a byte held in the input register stays there while stalled
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ir_valid && $stable(ir_byte) && $stable(ir_eos))
    else $error("input register lost a stalled byte");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to escaped-text converter: directed and
// random byte strings go in under both surrogate settings, and every escaped
// character is compared against a predictor of the expected text.
// ----------------------------------------------------------------------------
module tb_top;
  import ujse_pkg::*;

  // Input bytes with two-character escapes
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_FF     = 8'h0C;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_TAB    = 8'h09;

  localparam logic MODE_WIDE      = 1'b0;  // \UXXXXXXXX above the BMP
  localparam logic MODE_SURROGATE = 1'b1;  // \uXXXX\uXXXX above the BMP

  localparam int SETTLE_CYCLES = 12;    // pipeline drain before a config write
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all

  typedef struct {
    logic [7:0] ch;
    logic       run_last;
    logic       err;
    logic       done;
  } esc_char_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the escaped text of each accepted request and checks
  // results against it in order.
  // --------------------------------------------------------------------------
  class escape_scoreboard;
    logic [20:0] code_acc;
    logic [1:0]  cont_left;
    logic        dropping;
    logic        surrogate_mode;
    esc_char_t   expected_chars[$];
    int          mismatches;

    function new();
      code_acc       = '0;
      cont_left      = '0;
      dropping       = 1'b0;
      surrogate_mode = MODE_SURROGATE;
      mismatches     = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_chars.size();
    endfunction

    function void set_mode(logic m);
      surrogate_mode = m;
    endfunction

    function void push_char(logic [7:0] c);
      esc_char_t e;
      e.ch       = c;
      e.run_last = 1'b0;
      e.err      = 1'b0;
      e.done     = 1'b0;
      expected_chars.push_back(e);
    endfunction

    function logic [7:0] nibble_char(logic [3:0] n);
      if (n < 4'd10) begin
        return 8'h30 + {4'd0, n};
      end
      return 8'h61 + {4'd0, n - 4'd10};
    endfunction

    function void push_hex(logic [31:0] v, int digits);
      for (int d = digits - 1; d >= 0; d--) begin
        push_char(nibble_char(v[4*d +: 4]));
      end
    endfunction

    function void push_u4(logic [15:0] v);
      push_char(CH_BSLASH);
      push_char(CH_LOW_U);
      push_hex({16'd0, v}, 4);
    endfunction

    function void push_code(logic [20:0] u);
      logic [20:0] off;
      if (u < PLANE1_BASE) begin
        push_u4(u[15:0]);
      end else if (surrogate_mode) begin
        off = u - PLANE1_BASE;
        push_u4(HI_SURR + {6'd0, off[19:10]});
        push_u4(LO_SURR + {6'd0, off[9:0]});
      end else begin
        push_char(CH_BSLASH);
        push_char(CH_UP_U);
        push_hex({11'd0, u}, 8);
      end
    endfunction

    // Malformed input: one zero character with the error mark; the rest of
    // the string is dropped unless this byte already ends it.
    function void flag_error(logic eos);
      push_char(CH_NUL);
      expected_chars[expected_chars.size()-1].err = 1'b1;
      code_acc  = '0;
      cont_left = '0;
      dropping  = !eos;
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      int         first;
      logic [7:0] letter;
      first  = expected_chars.size();
      letter = CH_NUL;
      if (dropping) begin
        if (eos) begin
          dropping  = 1'b0;
          code_acc  = '0;
          cont_left = '0;
        end
        return;
      end
      if (cont_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          flag_error(eos);
        end else begin
          code_acc  = {code_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left != 2'd0) begin
            if (!eos) return;
            flag_error(1'b1);
          end else if (code_acc > CODE_MAX) begin
            flag_error(eos);
          end else begin
            push_code(code_acc);
            code_acc = '0;
          end
        end
      end else if (b[7:6] == 2'b11) begin
        if (b >= 8'hF8) begin
          flag_error(eos);
        end else begin
          if (b < 8'hE0) begin
            code_acc  = {16'd0, b[4:0]};
            cont_left = 2'd1;
          end else if (b < 8'hF0) begin
            code_acc  = {17'd0, b[3:0]};
            cont_left = 2'd2;
          end else begin
            code_acc  = {18'd0, b[2:0]};
            cont_left = 2'd3;
          end
          if (!eos) return;
          flag_error(1'b1);
        end
      end else begin
        case (b)
          BYTE_QUOTE:  letter = BYTE_QUOTE;
          BYTE_BSLASH: letter = BYTE_BSLASH;
          BYTE_BS:     letter = "b";
          BYTE_FF:     letter = "f";
          BYTE_LF:     letter = "n";
          BYTE_CR:     letter = "r";
          BYTE_TAB:    letter = "t";
          default:     letter = CH_NUL;
        endcase
        if (letter != CH_NUL) begin
          push_char(CH_BSLASH);
          push_char(letter);
        end else begin
          push_char(b);
        end
      end
      if (eos) begin
        code_acc  = '0;
        cont_left = '0;
        dropping  = 1'b0;
      end
      if (expected_chars.size() > first) begin
        expected_chars[expected_chars.size()-1].run_last = 1'b1;
        expected_chars[expected_chars.size()-1].done     = eos;
      end
    endfunction

    task check_result(logic [7:0] ch, logic rl, logic err, logic done);
      esc_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result char=%h", ch));
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch)
        report($sformatf("out_char %h, expected %h", ch, e.ch));
      if (rl !== e.run_last)
        report($sformatf("run_last %b, expected %b", rl, e.run_last));
      if (err !== e.err)
        report($sformatf("error_flag %b, expected %b", err, e.err));
      if (done !== e.done)
        report($sformatf("string_done %b, expected %b", done, e.done));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       run_last;
  logic       error_flag;
  logic       string_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  logic quiet_tail = 1'b0;  // no idling on either side near the end
  int   stall_hold = 0;
  int   idle_count = 0;
  int   bytes_sent = 0;

  escape_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_json_string_escaper dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .run_last     (run_last),
    .error_flag   (error_flag),
    .string_done  (string_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts between free-running stretches
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!out_stall && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 12);
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 20);
    end
  end

  // Result monitor: sampled at the edge where the handshake completes
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_char, run_last, error_flag, string_done);
    end
  end

  // Watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL utf8_json_string_escaper");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Holds the byte until accepted; valid stays high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(b, eos);
    bytes_sent++;
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      if (!quiet_tail && $urandom_range(0, 5) == 0)
        idle_input($urandom_range(1, 13));
      send_byte(s[i], i == s.size() - 1);
    end
  endtask

  // Sender pauses until the predictor has nothing outstanding.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mode change only with the pipeline empty; bytes that emit nothing may
  // still be in flight after the last expected character, hence the settle.
  task automatic write_mode(input logic m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed UTF-8 with random content; about one string in five
  // is damaged by a replaced, dropped or invalid lead byte.
  task automatic send_random_string();
    logic [7:0] s[$];
    logic [7:0] lead;
    logic [7:0] esc_bytes[7];
    int         nchars;
    int         kind;
    int         pos;
    esc_bytes = '{BYTE_QUOTE, BYTE_BSLASH, BYTE_BS, BYTE_FF, BYTE_LF, BYTE_CR, BYTE_TAB};
    nchars = $urandom_range(1, 10);
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        if ($urandom_range(0, 3) == 0) s.push_back(esc_bytes[$urandom_range(0, 6)]);
        else s.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 50) begin
        s.push_back(cont_byte());  // stray continuation, copied through
      end else if (kind < 65) begin
        s.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        s.push_back(cont_byte());
      end else if (kind < 80) begin
        s.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        s.push_back(cont_byte());
        s.push_back(cont_byte());
      end else begin
        // F4 with a second byte past 8F, or F5..F7, lands above U+10FFFF
        if ($urandom_range(0, 7) == 0) lead = 8'($urandom_range(8'hF0, 8'hF7));
        else lead = 8'($urandom_range(8'hF0, 8'hF4));
        s.push_back(lead);
        if (lead == 8'hF4 && $urandom_range(0, 3) != 0)
          s.push_back(8'($urandom_range(8'h80, 8'h8F)));
        else
          s.push_back(cont_byte());
        s.push_back(cont_byte());
        s.push_back(cont_byte());
      end
    end
    if ($urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0: s[pos] = 8'($urandom_range(0, 255));
        1: if (s.size() > 1) s.delete(pos);
        default: s.insert(pos, 8'($urandom_range(8'hF8, 8'hFF)));
      endcase
    end
    send_string(s);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] s[$];
    int         target;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings with the reset setting (surrogate pairs).
    // Control bytes, escapes, a stray continuation and a two-byte character.
    s = '{8'h00, 8'h7F, BYTE_QUOTE, BYTE_BSLASH, BYTE_BS, BYTE_FF, BYTE_LF,
          BYTE_CR, BYTE_TAB, 8'h80, 8'hC3, 8'hA9};
    send_string(s);
    // Three-byte euro sign, then a four-byte emoji as a surrogate pair
    s = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_string(s);
    // Code point above U+10FFFF on the final byte
    s = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string(s);
    // Invalid lead byte FF, then the rest of the string is dropped
    s = '{8'hFF, 8'h41};
    send_string(s);
    // Missing continuation byte
    s = '{8'hC3, 8'h41};
    send_string(s);
    // String ends inside a sequence
    s = '{8'hE2, 8'h82};
    send_string(s);

    // \U form
    write_mode(MODE_WIDE);
    s = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(s);
    target = bytes_sent + 100;
    while (bytes_sent < target) begin
      send_random_string();
      if (bytes_sent > target - 60 && bytes_sent < target - 50)
        drain_results();  // let the output side run completely dry once
    end

    // Surrogate pairs
    write_mode(MODE_SURROGATE);
    target = bytes_sent + 100;
    while (bytes_sent < target) send_random_string();

    // Back to \U; idling stops for the last stretch
    write_mode(MODE_WIDE);
    target = bytes_sent + 100;
    while (bytes_sent < target) begin
      if (bytes_sent > target - 50) quiet_tail = 1'b1;
      send_random_string();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected characters never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("PASS utf8_json_string_escaper");
    end else begin
      $display("FAIL utf8_json_string_escaper");
    end
    $finish;
  end

endmodule

// ===== utf8_json_string_escaper.f =====
rtl/core/ujse_pkg.sv
rtl/core/ujse_decode.sv
rtl/core/ujse_emit.sv
rtl/core/utf8_json_string_escaper.sv
tb/sv/tb_top.sv
